// ----- hdl/jas_pkg.sv -----
// Shared types and constants for the joystick axis smoothing block.
// Depends on nothing; every other file takes names from here by scope.
`default_nettype none

package jas_pkg;

  localparam int WINDOW    = 16;
  localparam int CHANNELS  = 3;
  localparam int SAMPLE_W  = 12;
  localparam int BUTTON_W  = 16;
  localparam int AXIS_W    = 10;
  localparam logic [AXIS_W-1:0] AXIS_FULL = 10'd1023;

  localparam int POS_W     = $clog2(WINDOW);
  localparam int MEM_DEPTH = CHANNELS * WINDOW;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int SUM_MAX   = WINDOW * 1023;
  localparam int SUM_W     = $clog2(SUM_MAX + 1);

  // sum / WINDOW as a multiply by a rounded-up reciprocal, exact below 2**SUM_W
  localparam int LOG_W       = $clog2(WINDOW);
  localparam int RECIP_SHIFT = SUM_W + LOG_W;
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int RECIP_W     = SUM_W + 2;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int PEND_W    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    CH_PITCH = 2'd0,
    CH_ROLL  = 2'd1,
    CH_YAW   = 2'd2
  } ch_t;

  // one window update, issued to the filter datapath
  typedef struct packed {
    logic              valid;
    ch_t               ch;
    logic [POS_W-1:0]  pos;
    logic              lap;    // slot not yet rewritten since the first item
    logic              prime;  // first item: sum starts at value * WINDOW
    logic [AXIS_W-1:0] value;
    logic [AXIS_W-1:0] fill;   // old slot value while lap is set
  } op_t;

  typedef struct packed {
    logic              valid;
    ch_t               ch;
    logic [AXIS_W-1:0] avg;
  } res_t;

  typedef struct packed {
    logic [AXIS_W-1:0] pitch_axis;
    logic [AXIS_W-1:0] roll_axis;
    logic [AXIS_W-1:0] throttle_axis;
    logic [AXIS_W-1:0] yaw_axis;
    logic [AXIS_W-1:0] button_field;
  } report_t;

endpackage

`default_nettype wire

// ----- hdl/jas_if.sv -----
// Valid/ready channel interfaces for sample sets and reports.
// Depends on jas_pkg for field widths.
`default_nettype none

interface jas_in_if;
  logic                           valid;
  logic                           ready;
  logic [jas_pkg::SAMPLE_W-1:0]   pitch_sample;
  logic [jas_pkg::SAMPLE_W-1:0]   roll_sample;
  logic [jas_pkg::SAMPLE_W-1:0]   throttle_sample;
  logic [jas_pkg::SAMPLE_W-1:0]   yaw_sample;
  logic [jas_pkg::BUTTON_W-1:0]   button_bits;

  modport source (output valid, pitch_sample, roll_sample, throttle_sample, yaw_sample,
                  button_bits, input ready);
  modport sink   (input valid, pitch_sample, roll_sample, throttle_sample, yaw_sample,
                  button_bits, output ready);
endinterface

interface jas_out_if;
  logic                         valid;
  logic                         ready;
  logic [jas_pkg::AXIS_W-1:0]   pitch_axis;
  logic [jas_pkg::AXIS_W-1:0]   roll_axis;
  logic [jas_pkg::AXIS_W-1:0]   throttle_axis;
  logic [jas_pkg::AXIS_W-1:0]   yaw_axis;
  logic [jas_pkg::AXIS_W-1:0]   button_field;

  modport source (output valid, pitch_axis, roll_axis, throttle_axis, yaw_axis,
                  button_field, input ready);
  modport sink   (input valid, pitch_axis, roll_axis, throttle_axis, yaw_axis,
                  button_field, output ready);
endinterface

`default_nettype wire

// ----- hdl/jas_window.sv -----
// Shared window memory and running sums for the three filtered axes.
// Depends on jas_pkg; one update per cycle, with the update and then the sum registered before the average comes out.
`default_nettype none

module jas_window (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire jas_pkg::op_t op,
  output jas_pkg::res_t     res
);

  logic [jas_pkg::AXIS_W-1:0] mem [jas_pkg::MEM_DEPTH];
  logic [jas_pkg::AXIS_W-1:0] rdata;
  logic [jas_pkg::ADDR_W-1:0] addr;

  jas_pkg::op_t               op_q;
  logic [jas_pkg::SUM_W-1:0]  sums [jas_pkg::CHANNELS];
  logic [jas_pkg::AXIS_W-1:0] old_value;
  logic [jas_pkg::SUM_W-1:0]  sum_base;
  logic [jas_pkg::SUM_W-1:0]  sum_next;

  logic                       valid_c;
  jas_pkg::ch_t               ch_c;
  logic [jas_pkg::SUM_W-1:0]  sum_c;
  logic [jas_pkg::PROD_W-1:0] prod;

  assign addr = jas_pkg::ADDR_W'(jas_pkg::ADDR_W'(op.ch) *
                                 jas_pkg::ADDR_W'(jas_pkg::WINDOW)
                                 + jas_pkg::ADDR_W'(op.pos));

  // read-before-write: rdata gets the slot's old value
  always_ff @(posedge clk) begin
    if (op.valid) begin
      rdata     <= mem[addr];
      mem[addr] <= op.value;
    end
  end

  // slots untouched since the first item still hold that item's value
  assign old_value = op_q.lap ? op_q.fill : rdata;
  assign sum_base  = op_q.prime
                   ? jas_pkg::SUM_W'(jas_pkg::SUM_W'(op_q.value) *
                                     jas_pkg::SUM_W'(jas_pkg::WINDOW))
                   : sums[op_q.ch];
  assign sum_next  = sum_base - jas_pkg::SUM_W'(old_value) + jas_pkg::SUM_W'(op_q.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q.valid <= 1'b0;
      valid_c    <= 1'b0;
      for (int i = 0; i < jas_pkg::CHANNELS; i++) begin
        sums[i] <= '0;
      end
    end else begin
      op_q    <= op;
      valid_c <= op_q.valid;
      if (op_q.valid) begin
        sums[op_q.ch] <= sum_next;
      end
    end
    ch_c  <= op_q.ch;
    sum_c <= sum_next;
  end

  assign prod = jas_pkg::PROD_W'(sum_c) *
                jas_pkg::PROD_W'(jas_pkg::RECIP_W'(jas_pkg::RECIP));

  assign res.valid = valid_c;
  assign res.ch    = ch_c;
  assign res.avg   = jas_pkg::AXIS_W'(prod >> jas_pkg::RECIP_SHIFT);

  a_res_follows_op: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> $past(op.valid, 2))
    else $error("average without a matching update");

  a_prime_at_slot_zero: assert property (@(posedge clk) disable iff (rst)
    op.valid && op.prime |-> op.lap && op.pos == '0)
    else $error("first item not placed at slot zero in the first lap");

  a_sum_bounded: assert property (@(posedge clk) disable iff (rst)
    op_q.valid |-> sum_next <= jas_pkg::SUM_W'(jas_pkg::SUM_MAX))
    else $error("running sum left the window range");

endmodule

`default_nettype wire

// ----- hdl/joystick_axis_smoothing_top.sv -----
// Top level of the joystick axis smoothing block: sequencing and report queue.
// Depends on jas_pkg, jas_if and jas_window.
`default_nettype none

// Takes one set of four converter samples and a button word per transfer and
// returns one report per set. Pitch, roll and yaw are cut to 10 bits and
// smoothed by a 16-slot moving average; the report carries filtered roll as
// pitch, 1023 minus filtered pitch as roll, throttle unfiltered, filtered yaw and the low
// ten button bits. The first set after reset fills every window with its own
// values, so the first report shows them unchanged; no clearing pass runs.
// The three axes share the single port of the window memory, one axis update
// per cycle, so a new set is taken only when the sequencer is idle or on yaw
// and fewer than four sets are in flight. A report is queued when its yaw
// average is out; a four-entry queue lets sets keep coming while reports wait.
module joystick_axis_smoothing_top (
  input wire logic  clk,
  input wire logic  rst,
  jas_in_if.sink    samples,
  jas_out_if.source report
);

  logic                        primed;
  logic                        first_lap;
  logic [jas_pkg::POS_W-1:0]   write_position;
  logic [jas_pkg::AXIS_W-1:0]  first_val [jas_pkg::CHANNELS];

  logic                        busy;
  jas_pkg::ch_t                ch;
  logic [jas_pkg::AXIS_W-1:0]  vals [jas_pkg::CHANNELS];
  logic [jas_pkg::POS_W-1:0]   pos;
  logic                        lap;
  logic                        prime;
  logic [jas_pkg::AXIS_W-1:0]  throttle;
  logic [jas_pkg::AXIS_W-1:0]  buttons;

  logic [jas_pkg::AXIS_W-1:0]  throttle_hold;
  logic [jas_pkg::AXIS_W-1:0]  buttons_hold;
  logic [jas_pkg::AXIS_W-1:0]  pitch_avg;
  logic [jas_pkg::AXIS_W-1:0]  roll_avg;

  jas_pkg::report_t            fifo [jas_pkg::OUT_DEPTH];
  logic [jas_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [jas_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic [jas_pkg::PEND_W-1:0]  count;
  logic [jas_pkg::PEND_W-1:0]  pending;

  logic                        in_fire;
  logic                        out_fire;
  logic                        push;
  logic                        accept_prime;
  logic [jas_pkg::POS_W-1:0]   accept_pos;
  logic                        accept_lap;
  jas_pkg::op_t                op;
  jas_pkg::res_t               res;
  jas_pkg::report_t            entry;

  assign samples.ready = (!busy || ch == jas_pkg::CH_YAW) &&
                         pending < jas_pkg::PEND_W'(jas_pkg::OUT_DEPTH);
  assign in_fire  = samples.valid && samples.ready;
  assign out_fire = report.valid && report.ready;
  assign push     = res.valid && res.ch == jas_pkg::CH_YAW;

  assign accept_prime = !primed;
  assign accept_pos   = accept_prime ? '0 : write_position;
  assign accept_lap   = accept_prime || first_lap;

  assign op.valid = busy;
  assign op.ch    = ch;
  assign op.pos   = pos;
  assign op.lap   = lap;
  assign op.prime = prime;
  assign op.value = vals[ch];
  assign op.fill  = first_val[ch];

  jas_window u_window (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .res (res)
  );

  // sequencer: one axis update per cycle, next set may start right after yaw
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      ch             <= jas_pkg::CH_PITCH;
      primed         <= 1'b0;
      first_lap      <= 1'b0;
      write_position <= '0;
    end else begin
      if (in_fire) begin
        busy      <= 1'b1;
        ch        <= jas_pkg::CH_PITCH;
        primed    <= 1'b1;
        first_lap <= accept_lap &&
                     accept_pos != jas_pkg::POS_W'(jas_pkg::WINDOW - 1);
        if (accept_pos == jas_pkg::POS_W'(jas_pkg::WINDOW - 1)) begin
          write_position <= '0;
        end else begin
          write_position <= accept_pos + 1'b1;
        end
      end else if (busy) begin
        case (ch)
          jas_pkg::CH_PITCH: ch <= jas_pkg::CH_ROLL;
          jas_pkg::CH_ROLL:  ch <= jas_pkg::CH_YAW;
          default:           busy <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      vals[0]  <= samples.pitch_sample[jas_pkg::SAMPLE_W-1:2];
      vals[1]  <= samples.roll_sample[jas_pkg::SAMPLE_W-1:2];
      vals[2]  <= samples.yaw_sample[jas_pkg::SAMPLE_W-1:2];
      throttle <= samples.throttle_sample[jas_pkg::SAMPLE_W-1:2];
      buttons  <= samples.button_bits[jas_pkg::AXIS_W-1:0];
      pos      <= accept_pos;
      lap      <= accept_lap;
      prime    <= accept_prime;
      if (accept_prime) begin
        first_val[0] <= samples.pitch_sample[jas_pkg::SAMPLE_W-1:2];
        first_val[1] <= samples.roll_sample[jas_pkg::SAMPLE_W-1:2];
        first_val[2] <= samples.yaw_sample[jas_pkg::SAMPLE_W-1:2];
      end
    end
    // hold the unfiltered fields until the yaw average arrives
    if (busy && ch == jas_pkg::CH_YAW) begin
      throttle_hold <= throttle;
      buttons_hold  <= buttons;
    end
    if (res.valid && res.ch == jas_pkg::CH_PITCH) begin
      pitch_avg <= res.avg;
    end
    if (res.valid && res.ch == jas_pkg::CH_ROLL) begin
      roll_avg <= res.avg;
    end
  end

  assign entry.pitch_axis    = roll_avg;
  assign entry.roll_axis     = jas_pkg::AXIS_FULL - pitch_avg;
  assign entry.throttle_axis = throttle_hold;
  assign entry.yaw_axis      = res.avg;
  assign entry.button_field  = buttons_hold;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pending <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count   <= count + jas_pkg::PEND_W'(push) - jas_pkg::PEND_W'(out_fire);
      pending <= pending + jas_pkg::PEND_W'(in_fire) - jas_pkg::PEND_W'(out_fire);
    end
  end

  assign report.valid         = count != '0;
  assign report.pitch_axis    = fifo[rd_ptr].pitch_axis;
  assign report.roll_axis     = fifo[rd_ptr].roll_axis;
  assign report.throttle_axis = fifo[rd_ptr].throttle_axis;
  assign report.yaw_axis      = fifo[rd_ptr].yaw_axis;
  assign report.button_field  = fifo[rd_ptr].button_field;

  a_pending_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= jas_pkg::PEND_W'(jas_pkg::OUT_DEPTH))
    else $error("more sets in flight than the report queue holds");

  a_queue_within_pending: assert property (@(posedge clk) disable iff (rst)
    count <= pending)
    else $error("report queue holds more than the sets taken");

  a_start_at_pitch: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy && ch == jas_pkg::CH_PITCH)
    else $error("sequencer did not restart at pitch after a transfer");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> count < jas_pkg::PEND_W'(jas_pkg::OUT_DEPTH))
    else $error("report pushed into a full queue");

endmodule

`default_nettype wire
